>>> rtl/ghic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghic_pkg
// Shared sizes, widths and types for the gift-wrap hull inside-count block.
// ----------------------------------------------------------------------------
package ghic_pkg;

    // point set sizing
    localparam int MAX_POINTS = 16;
    localparam int COORD_BITS = 16;
    localparam int MIN_SET    = 3;

    // index and count widths
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // point store: two banks so one set loads while the previous one is walked
    localparam int BANK_DEPTH = 1 << IDX_W;
    localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
    localparam int RAM_AW     = IDX_W + 1;
    localparam int PT_W       = 2 * COORD_BITS;

    // orientation arithmetic
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int VAL_W      = PROD_W + 1;

    // set queue between loader and walker
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int MAX_SETS   = 2;

    // stream word layout
    localparam int FIELD_W    = 16;
    localparam int IN_W       = 2 * FIELD_W;
    localparam int INSIDE_W   = 5;
    localparam int OUT_W      = 8;

    // one loaded set, ready to be walked
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] n;
    } set_cmd_t;

    // queue status seen by the walker and the top level
    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
        set_cmd_t          head;
    } q_stat_t;

endpackage

>>> rtl/ghic_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghic_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ghic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ghic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghic_front
// Point loader: writes each accepted point, up to MAX_POINTS per set, into the
// active bank and hands a finished set to the walk queue on the last point.
// ----------------------------------------------------------------------------
module ghic_front
    import ghic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // px [15:0], py [31:16]
    input  logic              s_axis_tlast,   // last_point
    input  logic              sets_full,
    output logic              ram_we,
    output logic [RAM_AW-1:0] ram_waddr,
    output logic [PT_W-1:0]   ram_wdata,
    output logic              push,
    output set_cmd_t          push_cmd
);

    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic             bank_reg, bank_next;
    logic             accept, has_room;

    // handshake and store decode
    assign s_axis_tready = !sets_full;
    assign accept        = s_axis_tvalid && !sets_full;
    assign has_room      = count_reg < CNT_W'(MAX_POINTS);
    assign count_inc     = has_room ? count_reg + CNT_W'(1) : count_reg;

    // point write, x in the low half
    assign ram_we    = accept && has_room;
    assign ram_waddr = {bank_reg, count_reg[IDX_W-1:0]};
    assign ram_wdata = {s_axis_tdata[FIELD_W +: COORD_BITS], s_axis_tdata[COORD_BITS-1:0]};

    // close the set on the last point
    assign push          = accept && s_axis_tlast;
    assign push_cmd.bank = bank_reg;
    assign push_cmd.n    = count_inc;

    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                count_next = '0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

>>> rtl/ghic_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghic_queue
// Short FIFO of loaded sets between the loader and the hull walker.
// ----------------------------------------------------------------------------
module ghic_queue
    import ghic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  set_cmd_t push_cmd,
    input  logic     pop,
    output q_stat_t  stat
);

    set_cmd_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assign stat.valid = count_reg != '0;
    assign stat.count = count_reg;
    assign stat.head  = entry_reg[rd_ptr_reg];

    // no write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QDEPTH)) || pop)
        else $error("set queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("set queue underflow");

endmodule

>>> rtl/ghic_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghic_walk
// Hull walker: finds the leftmost point, wraps the hull one vertex at a time
// with a full scan per vertex, and registers the result word; short sets skip the walk.
// ----------------------------------------------------------------------------
module ghic_walk
    import ghic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_stat_t           q_stat,
    output logic              pop,
    output logic              busy,
    output logic [RAM_AW-1:0] ram_raddr,
    input  logic [PT_W-1:0]   ram_rdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // inside_count [4:0], all_on_hull [5],
                                              // too_few [6], walk_overrun [7]
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIN_RD,
        S_MIN_CHK,
        S_INIT,
        S_STEP,
        S_CAND_RD,
        S_CAND_LD,
        S_SCAN_RD,
        S_SCAN_MUL,
        S_SCAN_CMP,
        S_NEXT,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic                    bank_reg;
    logic [CNT_W-1:0]        n_reg, hull_len_reg;
    logic [IDX_W-1:0]        i_reg, start_idx_reg, cur_idx_reg, cand_idx_reg;
    logic [COORD_BITS-1:0]   start_x_reg, start_y_reg, cur_x_reg, cur_y_reg;
    logic [COORD_BITS-1:0]   cand_x_reg, cand_y_reg, b_x_reg, b_y_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic                    few_reg, overrun_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    logic [COORD_BITS-1:0]   rd_x, rd_y;
    logic signed [DIFF_W-1:0] dy_ba, dx_cb, dx_ba, dy_cb;
    logic signed [VAL_W-1:0]  val;
    logic                    ccw, i_last, out_free;
    logic [CNT_W-1:0]        cur_plus;
    logic [IDX_W-1:0]        cand_first, rd_idx;
    logic [CNT_W-1:0]        inside_full;
    logic [INSIDE_W-1:0]     inside_cnt;
    logic                    all_on;

    assign rd_x = ram_rdata[COORD_BITS-1:0];
    assign rd_y = ram_rdata[PT_W-1:COORD_BITS];

    // read address: candidate fetch or scan index
    assign rd_idx    = (state_reg == S_CAND_RD) ? cand_idx_reg : i_reg;
    assign ram_raddr = {bank_reg, rd_idx};

    // orientation of (cur, scanned, cand): two products, then their difference
    assign dy_ba = $signed({1'b0, rd_y}) - $signed({1'b0, cur_y_reg});
    assign dx_cb = $signed({1'b0, cand_x_reg}) - $signed({1'b0, rd_x});
    assign dx_ba = $signed({1'b0, rd_x}) - $signed({1'b0, cur_x_reg});
    assign dy_cb = $signed({1'b0, cand_y_reg}) - $signed({1'b0, rd_y});
    assign val   = $signed({prod_a_reg[PROD_W-1], prod_a_reg})
                 - $signed({prod_b_reg[PROD_W-1], prod_b_reg});
    assign ccw   = val[VAL_W-1];

    // scan bounds and first candidate after the current vertex
    assign i_last     = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;
    assign cur_plus   = CNT_W'(cur_idx_reg) + CNT_W'(1);
    assign cand_first = (cur_plus == n_reg) ? '0 : cur_plus[IDX_W-1:0];

    // result fields
    assign inside_full = n_reg - hull_len_reg;
    assign inside_cnt  = (few_reg || overrun_reg) ? '0 : INSIDE_W'(inside_full);
    assign all_on      = !few_reg && !overrun_reg && (hull_len_reg == n_reg);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pop           = (state_reg == S_IDLE) && q_stat.valid;
    assign busy          = state_reg != S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // walk sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            n_reg         <= '0;
            hull_len_reg  <= '0;
            i_reg         <= '0;
            start_idx_reg <= '0;
            cur_idx_reg   <= '0;
            cand_idx_reg  <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cand_x_reg    <= '0;
            cand_y_reg    <= '0;
            b_x_reg       <= '0;
            b_y_reg       <= '0;
            prod_a_reg    <= '0;
            prod_b_reg    <= '0;
            few_reg       <= 1'b0;
            overrun_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // the done state reloads the word itself when it is taken
            if (m_axis_tvalid && m_axis_tready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_stat.valid)
                    begin
                        bank_reg     <= q_stat.head.bank;
                        n_reg        <= q_stat.head.n;
                        hull_len_reg <= '0;
                        overrun_reg  <= 1'b0;
                        i_reg        <= '0;
                        if (q_stat.head.n < CNT_W'(MIN_SET))
                        begin
                            few_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            few_reg   <= 1'b0;
                            state_reg <= S_MIN_RD;
                        end
                    end
                end
                S_MIN_RD:
                begin
                    state_reg <= S_MIN_CHK;
                end
                // first point of smallest x
                S_MIN_CHK:
                begin
                    if (i_reg == '0 || rd_x < start_x_reg)
                    begin
                        start_idx_reg <= i_reg;
                        start_x_reg   <= rd_x;
                        start_y_reg   <= rd_y;
                    end
                    if (i_last)
                    begin
                        state_reg <= S_INIT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_MIN_RD;
                    end
                end
                S_INIT:
                begin
                    cur_idx_reg <= start_idx_reg;
                    cur_x_reg   <= start_x_reg;
                    cur_y_reg   <= start_y_reg;
                    state_reg   <= S_STEP;
                end
                // add one hull vertex or stop on overrun
                S_STEP:
                begin
                    if (hull_len_reg >= n_reg)
                    begin
                        overrun_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        hull_len_reg <= hull_len_reg + CNT_W'(1);
                        cand_idx_reg <= cand_first;
                        state_reg    <= S_CAND_RD;
                    end
                end
                S_CAND_RD:
                begin
                    state_reg <= S_CAND_LD;
                end
                S_CAND_LD:
                begin
                    cand_x_reg <= rd_x;
                    cand_y_reg <= rd_y;
                    i_reg      <= '0;
                    state_reg  <= S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_MUL;
                end
                S_SCAN_MUL:
                begin
                    b_x_reg    <= rd_x;
                    b_y_reg    <= rd_y;
                    prod_a_reg <= dy_ba * dx_cb;
                    prod_b_reg <= dx_ba * dy_cb;
                    state_reg  <= S_SCAN_CMP;
                end
                // counterclockwise turn replaces the candidate
                S_SCAN_CMP:
                begin
                    if (ccw)
                    begin
                        cand_idx_reg <= i_reg;
                        cand_x_reg   <= b_x_reg;
                        cand_y_reg   <= b_y_reg;
                    end
                    if (i_last)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_NEXT:
                begin
                    cur_idx_reg <= cand_idx_reg;
                    cur_x_reg   <= cand_x_reg;
                    cur_y_reg   <= cand_y_reg;
                    state_reg   <= (cand_idx_reg == start_idx_reg) ? S_DONE : S_STEP;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {overrun_reg, few_reg, all_on, inside_cnt};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // the walk never records more vertices than the set holds
    a_hull_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hull_len_reg <= n_reg)
        else $error("hull length beyond point count");

    // scan reads stay inside the loaded set
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD || state_reg == S_MIN_RD) |-> CNT_W'(i_reg) < n_reg)
        else $error("scan index outside set");

    // a new result only comes out of the done state, never with both error flags
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE) && !(few_reg && overrun_reg))
        else $error("result word loaded outside done state");

endmodule

>>> rtl/gift_wrap_hull_inside_count_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gift_wrap_hull_inside_count_top
// Jarvis-march convex hull over a loaded point set; reports the number of
// points off the hull plus convex, too-few and overrun flags.
// ----------------------------------------------------------------------------
//  port group | dir | word contents (low bit up)
//  s_axis     | in  | tdata: px [15:0], py [31:16]; tlast: last_point
//  m_axis     | out | tdata: inside_count [4:0], all_on_hull [5], too_few [6],
//             |     |        walk_overrun [7]
//
//  loading takes one cycle per point unless the input stalls; the walk first
//  finds the leftmost point, then wraps the hull with a full scan per vertex,
//  through the single read port of the store and the two-stage orientation test.
//  two sets may be outstanding (one loading, one queued or walking); the input
//  stalls while two finished sets wait. reset is asynchronous, active low,
//  and clears the queue, the counters and the result valid.
module gift_wrap_hull_inside_count_top
    import ghic_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // px [15:0], py [31:16]
    input  logic             s_axis_tlast,   // last_point
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // inside_count [4:0], all_on_hull [5],
                                             // too_few [6], walk_overrun [7]
);

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [PT_W-1:0]   ram_wdata, ram_rdata;
    logic              push, pop, busy, sets_full;
    set_cmd_t          push_cmd;
    q_stat_t           q_stat;
    logic [QCNT_W:0]   outstanding;

    // sets queued or being walked
    assign outstanding = {1'b0, q_stat.count} + {{QCNT_W{1'b0}}, busy};
    assign sets_full   = outstanding >= (QCNT_W + 1)'(MAX_SETS);

    // point loader
    ghic_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .sets_full     (sets_full),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // two-bank point store
    ghic_ram #(
        .WIDTH (PT_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // set queue
    ghic_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .stat     (q_stat)
    );

    // hull walker and result register
    ghic_walk u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop           (pop),
        .busy          (busy),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
